// File: hdl/tea_pkg.sv
// Package for the TEA block cipher: widths, round count, pipeline payload
// and key types, register index codes and the per-round sum function.
// No dependencies.
package tea_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned ROUNDS    = 32;
  localparam int unsigned NUM_CELLS = 2 * ROUNDS;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [WORD_W-1:0] TEA_DELTA = 32'h9e3779b9;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] KEY_IDX0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] KEY_IDX1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] KEY_IDX2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] KEY_IDX3 = 2'd3;

  localparam logic FUNC_ENC = 1'b0;
  localparam logic FUNC_DEC = 1'b1;

  typedef struct packed {
    logic              func;
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] z;
  } tea_blk_t;

  typedef struct packed {
    logic [WORD_W-1:0] k0;
    logic [WORD_W-1:0] k1;
    logic [WORD_W-1:0] k2;
    logic [WORD_W-1:0] k3;
  } tea_key_t;

  // Running sum after n delta steps, modulo 2^32 (elaboration-time only)
  function automatic logic [WORD_W-1:0] round_sum(input int unsigned n);
    logic [2*WORD_W-1:0] prod;
    prod = (2*WORD_W)'(TEA_DELTA) * (2*WORD_W)'(n);
    return prod[WORD_W-1:0];
  endfunction

endpackage

// File: hdl/tea_in_if.sv
// Input request channel of the TEA block cipher: valid/ready plus block.
// Depends on tea_pkg.
interface tea_in_if;
  import tea_pkg::*;
  logic              valid;
  logic              ready;
  logic              func;
  logic [WORD_W-1:0] block_lo;
  logic [WORD_W-1:0] block_hi;

  modport source(output valid, func, block_lo, block_hi, input ready);
  modport sink(input valid, func, block_lo, block_hi, output ready);
endinterface

// Result channel of the TEA block cipher: valid/ready plus block.
interface tea_out_if;
  import tea_pkg::*;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] result_lo;
  logic [WORD_W-1:0] result_hi;

  modport source(output valid, result_lo, result_hi, input ready);
  modport sink(input valid, result_lo, result_hi, output ready);
endinterface

// File: hdl/tea_block_cipher_top.sv
// Top level of the TEA block cipher: key bank and a chain of half-round cells.
// Depends on tea_pkg, tea_in_if/tea_out_if, tea_key_bank, tea_round_cell.
//
// Each request carries a 64-bit block and an encrypt/decrypt select; the
// result is the block after 32 TEA rounds under the 128-bit key in
// registers 0..3. The datapath is a chain of 64 registered half-round
// cells; one block can enter every cycle unless a stall reaches the first
// cell. Every cell has its own slot, so a stalled output only holds the
// cells behind it once they fill; empty slots keep taking requests
// meanwhile. Write keys only while no block is in flight.
module tea_block_cipher_top (
  input  logic                          clk,
  input  logic                          rst_n,
  tea_in_if.sink                        in_ch,
  tea_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [tea_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [tea_pkg::WORD_W-1:0]    cfg_wdata
);
  import tea_pkg::*;

  tea_key_t key;
  logic     valid_w [0:NUM_CELLS];
  logic     ready_w [0:NUM_CELLS];
  tea_blk_t data_w  [0:NUM_CELLS];

  tea_key_bank u_keys (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .key       (key)
  );

  assign valid_w[0]       = in_ch.valid;
  assign data_w[0].func   = in_ch.func;
  assign data_w[0].y      = in_ch.block_lo;
  assign data_w[0].z      = in_ch.block_hi;
  assign in_ch.ready      = ready_w[0];

  for (genvar c = 0; c < NUM_CELLS; c++) begin : g_cell
    localparam int unsigned RND = c / 2;
    localparam logic [WORD_W-1:0] SUM_ENC = round_sum(RND + 1);
    localparam logic [WORD_W-1:0] SUM_DEC = round_sum(ROUNDS - RND);
    localparam logic HALF = 1'(c % 2);

    tea_round_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .half     (HALF),
      .sum_enc  (SUM_ENC),
      .sum_dec  (SUM_DEC),
      .key      (key),
      .up_valid (valid_w[c]),
      .up_ready (ready_w[c]),
      .up_data  (data_w[c]),
      .dn_valid (valid_w[c+1]),
      .dn_ready (ready_w[c+1]),
      .dn_data  (data_w[c+1])
    );
  end

  assign ready_w[NUM_CELLS] = out_ch.ready;
  assign out_ch.valid       = valid_w[NUM_CELLS];
  assign out_ch.result_lo   = data_w[NUM_CELLS].y;
  assign out_ch.result_hi   = data_w[NUM_CELLS].z;

endmodule

// File: hdl/tea_key_bank.sv
// Key register bank of the TEA block cipher, written through the cfg port.
// Depends on tea_pkg.
module tea_key_bank (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [tea_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [tea_pkg::WORD_W-1:0]     cfg_wdata,
  output tea_pkg::tea_key_t              key
);
  import tea_pkg::*;

  tea_key_t key_r;
  tea_key_t key_nxt;

  always_comb begin
    key_nxt = key_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        KEY_IDX0: key_nxt.k0 = cfg_wdata;
        KEY_IDX1: key_nxt.k1 = cfg_wdata;
        KEY_IDX2: key_nxt.k2 = cfg_wdata;
        KEY_IDX3: key_nxt.k3 = cfg_wdata;
        default:  key_nxt    = key_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else begin
      key_r <= key_nxt;
    end
  end

  assign key = key_r;

endmodule

// File: hdl/tea_round_cell.sv
// One half-round cell of the TEA pipeline: updates one half of the block
// with the mix of the other half, then registers it for the next cell.
// Depends on tea_pkg.
module tea_round_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       half,
  input  logic [tea_pkg::WORD_W-1:0] sum_enc,
  input  logic [tea_pkg::WORD_W-1:0] sum_dec,
  input  tea_pkg::tea_key_t          key,
  input  logic                       up_valid,
  output logic                       up_ready,
  input  tea_pkg::tea_blk_t          up_data,
  output logic                       dn_valid,
  input  logic                       dn_ready,
  output tea_pkg::tea_blk_t          dn_data
);
  import tea_pkg::*;

  logic              valid_r;
  logic              valid_nxt;
  tea_blk_t          data_r;
  tea_blk_t          data_nxt;
  logic              upd_z;
  logic [WORD_W-1:0] src;
  logic [WORD_W-1:0] dst;
  logic [WORD_W-1:0] ka;
  logic [WORD_W-1:0] kb;
  logic [WORD_W-1:0] sum;
  logic [WORD_W-1:0] mix;
  logic [WORD_W-1:0] dst_new;

  // Encrypt updates y then z; decrypt undoes z then y.
  assign upd_z = half ^ up_data.func;
  assign src   = upd_z ? up_data.y : up_data.z;
  assign dst   = upd_z ? up_data.z : up_data.y;
  assign ka    = upd_z ? key.k2 : key.k0;
  assign kb    = upd_z ? key.k3 : key.k1;
  assign sum   = (up_data.func == FUNC_DEC) ? sum_dec : sum_enc;

  assign mix = ((src << 4) + ka) ^ (src + sum) ^ ((src >> 5) + kb);
  assign dst_new = (up_data.func == FUNC_DEC) ? (dst - mix) : (dst + mix);

  // Take a new request whenever this slot is empty or drains this cycle
  assign up_ready = !valid_r || dn_ready;

  always_comb begin
    valid_nxt = up_ready ? up_valid : valid_r;
    data_nxt  = data_r;
    if (up_ready && up_valid) begin
      data_nxt.func = up_data.func;
      data_nxt.y    = upd_z ? up_data.y : dst_new;
      data_nxt.z    = upd_z ? dst_new : up_data.z;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

// File: hdl/tea_checker.sv
// Port-level checks for the TEA block cipher top, attached by bind.
// Depends on tea_pkg and tea_block_cipher_top.
module tea_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [tea_pkg::WORD_W-1:0] out_lo,
  input logic [tea_pkg::WORD_W-1:0] out_hi
);
  import tea_pkg::*;

  // Reset empties the chain
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A free output slot means every cell can advance, so input is open
  a_ready_when_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ready || !out_valid) |-> in_ready)
    else $error("input stalled while output drains");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> ($stable(out_lo) && $stable(out_hi)))
    else $error("result changed while stalled");

endmodule

bind tea_block_cipher_top tea_checker u_tea_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_lo    (out_ch.result_lo),
  .out_hi    (out_ch.result_hi)
);

// File: tb/tb.sv
// Self-checking testbench for tea_block_cipher_top: drives encrypt and
// decrypt requests under several keys and checks each result block.
// Depends on tea_pkg, tea_in_if, tea_out_if and the cipher RTL.
module tb;
  import tea_pkg::*;

  localparam int unsigned PHASE_ITEMS = 222;
  localparam int unsigned HOLD_AT     = 500;
  localparam int unsigned HOLD_LEN    = 300;
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned TAIL_CYCLES = 2 * NUM_CELLS;

  typedef struct packed {
    logic [WORD_W-1:0] lo;
    logic [WORD_W-1:0] hi;
  } result_blk_t;

  logic clk;
  logic rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [WORD_W-1:0]    cfg_wdata;

  tea_in_if  in_if();
  tea_out_if out_if();

  tea_block_cipher_top u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_if),
    .out_ch   (out_if),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  // Key as the block should hold it
  logic [WORD_W-1:0] key_words [4];

  tea_blk_t    pending_reqs[$];
  result_blk_t expected_blocks[$];

  bit idle_on;
  int unsigned mismatches;
  int unsigned reqs_accepted;
  int unsigned enc_accepted;
  int unsigned dec_accepted;
  int unsigned results_seen;
  int unsigned key_sets;
  int unsigned quiet_cycles;
  int unsigned hold_left;
  bit          hold_done;

  logic [2*WORD_W-1:0] corners [7] = '{
    64'h00000000_00000000, 64'hFFFFFFFF_FFFFFFFF, 64'h00000000_FFFFFFFF,
    64'hFFFFFFFF_00000000, 64'h80000000_00000001, 64'h00000001_80000000,
    64'hAAAAAAAA_55555555
  };

  function automatic logic [WORD_W-1:0] feistel_mix(input logic [WORD_W-1:0] x,
                                                    input logic [WORD_W-1:0] s,
                                                    input logic [WORD_W-1:0] ka,
                                                    input logic [WORD_W-1:0] kb);
    return ((x << 4) + ka) ^ (x + s) ^ ((x >> 5) + kb);
  endfunction

  function automatic result_blk_t cipher_block(input logic func,
                                               input logic [WORD_W-1:0] y_in,
                                               input logic [WORD_W-1:0] z_in);
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] z;
    logic [WORD_W-1:0] s;
    result_blk_t       res;
    y = y_in;
    z = z_in;
    if (func == FUNC_ENC) begin
      s = '0;
      for (int r = 0; r < ROUNDS; r++) begin
        s = s + TEA_DELTA;
        y = y + feistel_mix(z, s, key_words[KEY_IDX0], key_words[KEY_IDX1]);
        z = z + feistel_mix(y, s, key_words[KEY_IDX2], key_words[KEY_IDX3]);
      end
    end else begin
      // start from delta times the round count, wrapped to 32 bits
      s = TEA_DELTA * WORD_W'(ROUNDS);
      for (int r = 0; r < ROUNDS; r++) begin
        z = z - feistel_mix(y, s, key_words[KEY_IDX2], key_words[KEY_IDX3]);
        y = y - feistel_mix(z, s, key_words[KEY_IDX0], key_words[KEY_IDX1]);
        s = s - TEA_DELTA;
      end
    end
    res.lo = y;
    res.hi = z;
    return res;
  endfunction

  function automatic logic [WORD_W-1:0] random_word();
    unique case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return WORD_W'(1) << $urandom_range(WORD_W - 1);
      3:       return ~(WORD_W'(1) << $urandom_range(WORD_W - 1));
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_req(input logic func, input logic [WORD_W-1:0] lo,
                           input logic [WORD_W-1:0] hi);
    tea_blk_t req;
    req.func = func;
    req.y    = lo;
    req.z    = hi;
    pending_reqs.push_back(req);
  endtask

  // Encrypt a block, then decrypt what the cipher should return
  task automatic queue_round_trip(input logic [WORD_W-1:0] lo,
                                  input logic [WORD_W-1:0] hi);
    result_blk_t ct;
    ct = cipher_block(FUNC_ENC, lo, hi);
    queue_req(FUNC_ENC, lo, hi);
    queue_req(FUNC_DEC, ct.lo, ct.hi);
  endtask

  task automatic write_key(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    key_words[idx] = value;
  endtask

  task automatic load_key(input logic [WORD_W-1:0] k0, input logic [WORD_W-1:0] k1,
                          input logic [WORD_W-1:0] k2, input logic [WORD_W-1:0] k3);
    write_key(KEY_IDX0, k0);
    write_key(KEY_IDX1, k1);
    write_key(KEY_IDX2, k2);
    write_key(KEY_IDX3, k3);
    @(posedge clk);
    cfg_we <= 1'b0;
    key_sets++;
  endtask

  // Hold the sender until every queued request has come back
  task automatic wait_drain();
    @(negedge clk);
    while (pending_reqs.size() != 0 || in_if.valid || expected_blocks.size() != 0)
      @(negedge clk);
  endtask

  task automatic queue_random(input int unsigned count);
    int unsigned n;
    n = 0;
    while (n < count) begin
      if ($urandom_range(3) == 0) begin
        queue_round_trip(random_word(), random_word());
        n += 2;
      end else begin
        queue_req(1'($urandom_range(1)), random_word(), random_word());
        n++;
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Request driver
  always @(posedge clk) begin
    tea_blk_t req;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        expected_blocks.push_back(cipher_block(in_if.func, in_if.block_lo, in_if.block_hi));
        reqs_accepted++;
        if (in_if.func == FUNC_ENC) enc_accepted++;
        else dec_accepted++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (pending_reqs.size() != 0 && !(idle_on && $urandom_range(99) < 37)) begin
          req = pending_reqs.pop_front();
          in_if.valid    <= 1'b1;
          in_if.func     <= req.func;
          in_if.block_lo <= req.y;
          in_if.block_hi <= req.z;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result receiver: random back-pressure plus one long hold
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      hold_left    <= 0;
      hold_done    <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      out_if.ready <= 1'b0;
    end else if (!hold_done && results_seen >= HOLD_AT) begin
      hold_left    <= HOLD_LEN;
      hold_done    <= 1'b1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= !(idle_on && $urandom_range(99) < 37);
    end
  end

  // Result checker
  always @(posedge clk) begin
    result_blk_t exp_blk;
    if (rst_n && out_if.valid && out_if.ready) begin
      results_seen++;
      if (expected_blocks.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result lo=%h hi=%h", $time, out_if.result_lo,
                 out_if.result_hi);
      end else begin
        exp_blk = expected_blocks.pop_front();
        if (out_if.result_lo !== exp_blk.lo) begin
          mismatches++;
          $display("%0t: result_lo expected %h actual %h", $time, exp_blk.lo,
                   out_if.result_lo);
        end
        if (out_if.result_hi !== exp_blk.hi) begin
          mismatches++;
          $display("%0t: result_hi expected %h actual %h", $time, exp_blk.hi,
                   out_if.result_hi);
        end
      end
    end
  end

  // Watchdog: end the run if traffic stops
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no traffic for %0d cycles", $time, quiet_cycles);
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n          = 1'b0;
    in_if.valid    = 1'b0;
    in_if.func     = FUNC_ENC;
    in_if.block_lo = '0;
    in_if.block_hi = '0;
    out_if.ready   = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = KEY_IDX0;
    cfg_wdata      = '0;
    idle_on        = 1'b1;
    mismatches     = 0;
    reqs_accepted  = 0;
    enc_accepted   = 0;
    dec_accepted   = 0;
    results_seen   = 0;
    key_sets       = 1;
    quiet_cycles   = 0;
    for (int i = 0; i < 4; i++) key_words[i] = '0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Corner blocks in both directions under the all-zero reset key
    foreach (corners[i]) begin
      queue_req(FUNC_ENC, corners[i][2*WORD_W-1:WORD_W], corners[i][WORD_W-1:0]);
      queue_req(FUNC_DEC, corners[i][2*WORD_W-1:WORD_W], corners[i][WORD_W-1:0]);
    end
    queue_round_trip(32'h01234567, 32'h89ABCDEF);
    queue_round_trip('1, '0);
    wait_drain();

    load_key('1, '1, '1, '1);
    queue_random(PHASE_ITEMS);
    wait_drain();

    // Long stretch with no idling on either side
    idle_on = 1'b0;
    load_key($urandom, $urandom, $urandom, $urandom);
    queue_random(PHASE_ITEMS);
    wait_drain();
    idle_on = 1'b1;

    load_key('0, '1, 32'h80000000, 32'h7FFFFFFF);
    queue_random(PHASE_ITEMS);
    wait_drain();

    load_key($urandom, $urandom, $urandom, $urandom);
    queue_random(PHASE_ITEMS);
    wait_drain();

    load_key('1, '0, '1, '0);
    queue_random(PHASE_ITEMS);
    wait_drain();

    load_key($urandom, $urandom, $urandom, $urandom);
    queue_random(PHASE_ITEMS);
    wait_drain();

    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d requests (%0d encrypt, %0d decrypt) under %0d keys;",
             reqs_accepted, enc_accepted, dec_accepted, key_sets);
    $display("%0d results checked, %0d left outstanding.", results_seen,
             expected_blocks.size());
    if (mismatches == 0 && expected_blocks.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/tea_pkg.sv
hdl/tea_in_if.sv
hdl/tea_key_bank.sv
hdl/tea_round_cell.sv
hdl/tea_block_cipher_top.sv
hdl/tea_checker.sv
tb/tb.sv
